// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define PLD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define PLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/pld_pkg.sv -----
`default_nettype none

package pld_pkg;

  localparam int YEAR_W = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int ORD_W = 23;
  localparam int LEN_W = 22;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // floor(x * RECIP_100 / 2^19) == floor(x / 100) for x below 43690
  localparam logic [26:0] RECIP_100 = 27'd5243;

  // Stage 1: per-date terms after the constant multiplies
  typedef struct packed {
    logic [ORD_W-1:0]  y365;
    logic [12:0]       q4;
    logic [7:0]        q100;
    logic [6:0]        q400;
    logic [7:0]        qy;
    logic [YEAR_W-1:0] y;
    logic [8:0]        ms;
    logic              late;
    logic [DAY_W-1:0]  d;
  } dt1_t;

  // Stage 2: year part and month-plus-day part of the ordinal
  typedef struct packed {
    logic [ORD_W-1:0] year_days;
    logic [9:0]       month_days;
  } dt2_t;

  // Days in whole months before month index mi, common year
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] r;
    begin
      unique case (mi)
        4'd0:    r = 9'd0;
        4'd1:    r = 9'd31;
        4'd2:    r = 9'd59;
        4'd3:    r = 9'd90;
        4'd4:    r = 9'd120;
        4'd5:    r = 9'd151;
        4'd6:    r = 9'd181;
        4'd7:    r = 9'd212;
        4'd8:    r = 9'd243;
        4'd9:    r = 9'd273;
        4'd10:   r = 9'd304;
        4'd11:   r = 9'd334;
        default: r = 9'd365;
      endcase
      return r;
    end
  endfunction

  function automatic dt1_t pld_stage1(input logic [YEAR_W-1:0] y,
                                      input logic [MONTH_W-1:0] m,
                                      input logic [DAY_W-1:0] d);
    dt1_t        r;
    logic [14:0] t3;
    logic [14:0] t399;
    logic [26:0] p100;
    logic [26:0] p400;
    logic [26:0] py;
    logic [3:0]  mi;
    begin
      t3   = 15'(y) + 15'd3;
      t399 = 15'(y) + 15'd399;
      p100 = (27'(y) + 27'd99) * RECIP_100;
      p400 = 27'(t399[14:2]) * RECIP_100;
      py   = 27'(y) * RECIP_100;
      if (m == '0) begin
        mi = 4'd0;
      end else if (m > 4'd12) begin
        mi = 4'd12;
      end else begin
        mi = m - 4'd1;
      end
      r.y365 = ORD_W'(y) * ORD_W'(365);
      r.q4   = t3[14:2];
      r.q100 = p100[26:19];
      r.q400 = p400[25:19];
      r.qy   = py[26:19];
      r.y    = y;
      r.ms   = month_start(mi);
      r.late = (mi >= 4'd2);
      r.d    = d;
      return r;
    end
  endfunction

  function automatic dt2_t pld_stage2(input dt1_t a);
    dt2_t        r;
    logic [14:0] c100;
    logic        div100;
    logic        leap;
    begin
      c100   = 15'(a.qy) * 15'd100;
      div100 = (15'(a.y) == c100);
      leap   = ((a.y[1:0] == 2'd0) && !div100) || (div100 && (a.qy[1:0] == 2'd0));
      r.year_days  = a.y365 + ORD_W'(a.q4) - ORD_W'(a.q100) + ORD_W'(a.q400);
      r.month_days = 10'(a.ms) + 10'(a.d) + 10'(leap && a.late);
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/period_length_in_days.sv -----
// Days from start to end Gregorian date, one pair per word; 0 if end is not after start.
// Each accepted word passes the stage 1, 2 and 3 registers into the result register.
// Throughput: one word per cycle while the result side does not stall; four register
//   stages with per-stage valids, so bubbles close up while the result side stalls.
// Reset (rst, synchronous): clears all stage valids and the result valid.
`default_nettype none

module period_length_in_days import pld_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                date_valid,
  output logic               date_stall,
  input  wire [YEAR_W-1:0]   start_year,
  input  wire [MONTH_W-1:0]  start_month,
  input  wire [DAY_W-1:0]    start_day,
  input  wire [YEAR_W-1:0]   end_year,
  input  wire [MONTH_W-1:0]  end_month,
  input  wire [DAY_W-1:0]    end_day,
  output logic               length_valid,
  input  wire                length_stall,
  output logic [LEN_W-1:0]   length_days
);

  logic             v1, v2, v3;
  logic             en1, en2, en3, en_o;
  dt1_t             s1_a, s1_b;
  logic             s1_before;
  dt2_t             s2_a, s2_b;
  logic             s2_before;
  logic [ORD_W-1:0] s3_ord_a, s3_ord_b;
  logic             s3_before;
  logic             in_order;
  logic [ORD_W:0]   diff;
  logic [LEN_W-1:0] length_days_next;

  assign en_o = !length_valid || !length_stall;
  assign en3  = !v3 || en_o;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign date_stall = !en1;

  // field-wise order: year, then month, then day
  always_comb begin
    priority if (start_year != end_year) begin
      in_order = (start_year < end_year);
    end else if (start_month != end_month) begin
      in_order = (start_month < end_month);
    end else begin
      in_order = (start_day < end_day);
    end
  end

  always_comb begin
    diff = {1'b0, s3_ord_b} - {1'b0, s3_ord_a};
    priority if (!s3_before || diff[ORD_W]) begin
      length_days_next = '0;
    end else if (diff[ORD_W-1:LEN_W] != '0) begin
      length_days_next = LEN_MAX;
    end else begin
      length_days_next = diff[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      length_valid <= 1'b0;
    end else begin
      if (en1) v1 <= date_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en_o) length_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a      <= pld_stage1(start_year, start_month, start_day);
      s1_b      <= pld_stage1(end_year, end_month, end_day);
      s1_before <= in_order;
    end
    if (en2) begin
      s2_a      <= pld_stage2(s1_a);
      s2_b      <= pld_stage2(s1_b);
      s2_before <= s1_before;
    end
    if (en3) begin
      s3_ord_a  <= s2_a.year_days + ORD_W'(s2_a.month_days);
      s3_ord_b  <= s2_b.year_days + ORD_W'(s2_b.month_days);
      s3_before <= s2_before;
    end
    if (en_o) begin
      length_days <= length_days_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/pld_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module pld_checker import pld_pkg::*; (
  input wire                clk,
  input wire                rst,
  input wire                date_valid,
  input wire                date_stall,
  input wire [YEAR_W-1:0]   start_year,
  input wire [MONTH_W-1:0]  start_month,
  input wire [DAY_W-1:0]    start_day,
  input wire [YEAR_W-1:0]   end_year,
  input wire [MONTH_W-1:0]  end_month,
  input wire [DAY_W-1:0]    end_day,
  input wire                length_valid,
  input wire                length_stall,
  input wire [LEN_W-1:0]    length_days
);

  logic same_dates;

  assign same_dates = (start_year == end_year) && (start_month == end_month) &&
                      (start_day == end_day);

  `PLD_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !length_valid, "result valid after reset")

  `PLD_ASSERT(a_hold, clk, rst,
    length_valid && length_stall |=> length_valid && $stable(length_days),
    "stalled result word changed")

  // input only backs up when every stage is full behind a stalled result
  `PLD_ASSERT(a_backpressure, clk, rst,
    date_stall |-> length_valid && length_stall, "input stalled with room in pipe")

  // equal dates arrive as zero when the result side does not stall while the word drains
  `PLD_ASSERT(a_equal_zero, clk, rst,
    date_valid && !date_stall && same_dates ##1 !length_stall ##1 !length_stall
      ##1 !length_stall |=> length_valid && (length_days == '0),
    "equal dates gave nonzero length")

endmodule

bind period_length_in_days pld_checker u_pld_checker (.*);

`default_nettype wire
